### rtl/core/fpm_pkg.sv
// shared constants and types for the fenwick prefix-minimum block
package fpm_pkg;

   localparam int DEPTH_DEFAULT = 1024;

   localparam int OP_W    = 2;
   localparam int INDEX_W = 11;
   localparam int VALUE_W = 64;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam int REG_W   = PADDR_W - 2;

   localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [REG_W-1:0] REG_SIZE_IN_USE = 1'd0;

   localparam logic [INDEX_W-1:0] SIZE_RESET  = 11'd1024;
   localparam logic [VALUE_W-1:0] EMPTY_VALUE = 64'h3f3f_3f3f_3f3f_3f3f;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UP,
      ST_DOWN
   } state_type;

endpackage

### rtl/core/fenwick_prefix_minimum_top.sv
// top level of the fenwick prefix-minimum block
//
// commands: raise start with req_operation, req_index and req_value; the
// transfer happens at an edge where start is high and busy is low.
// update lowers one position along its upward lowbit path, query returns the
// minimum of positions 1..req_index (clamped to the size in use), clear
// refills every node with the empty value.
// a query result shows on rsp_prefix_min for one cycle with rsp_strobe high;
// the receiver has no way to stall it, it must take it in that cycle.
// each visited node takes one read on the node memory's single read port:
// an update visits every node on its path (at most log2(DEPTH)+1), a query
// delivers its result in the cycle after its last node read, and index zero
// queries strobe the cycle after the transfer. busy drops as the result appears.
// clear and reset run a sweep over all DEPTH entries writing the empty value,
// one entry per cycle, with busy high; the apb port stays usable during it.
// size_in_use sits at byte address 0 and resets to 1024.
module fenwick_prefix_minimum_top import fpm_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [INDEX_W-1:0] req_index,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_strobe,
   output logic [VALUE_W-1:0] rsp_prefix_min,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   localparam int AW = $clog2(DEPTH);

   logic [INDEX_W-1:0] size_in_use;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   fpm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .size_ff (size_in_use)
   );

   fpm_node_ram #(.DEPTH(DEPTH)) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   fpm_walker #(.DEPTH(DEPTH)) u_walker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_index      (req_index),
      .req_value      (req_value),
      .size_in_use    (size_in_use),
      .rsp_strobe     (rsp_strobe),
      .rsp_prefix_min (rsp_prefix_min),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

endmodule

### rtl/core/fpm_node_ram.sv
// tree node store: one write port, one registered read port
module fpm_node_ram import fpm_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [VALUE_W-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [VALUE_W-1:0]       rd_data_ff
);

   logic [VALUE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

### rtl/core/fpm_csr.sv
// apb register file holding the size in use
module fpm_csr import fpm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output logic [INDEX_W-1:0] size_ff
);

   logic               reg_hit;
   logic [INDEX_W-1:0] size_in;

   assign reg_hit = (paddr[PADDR_W-1:2] == REG_SIZE_IN_USE);
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? PDATA_W'(size_ff) : '0;

   always_comb begin
      size_in = size_ff;
      if (psel && penable && pwrite && reg_hit) begin
         size_in = pwdata[INDEX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

endmodule

### rtl/core/fpm_walker.sv
// sequencer walking lowbit paths through the node store, plus clearing pass
module fpm_walker import fpm_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [INDEX_W-1:0]       req_index,
   input  logic [VALUE_W-1:0]       req_value,
   input  logic [INDEX_W-1:0]       size_in_use,
   output logic                     rsp_strobe,
   output logic [VALUE_W-1:0]       rsp_prefix_min,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [VALUE_W-1:0]       wr_data,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [VALUE_W-1:0]       rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1) + 1;
   localparam int CW = (NW > INDEX_W) ? NW : INDEX_W;

   state_type          state_ff, state_in;
   logic [NW-1:0]      node_ff, node_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [VALUE_W-1:0] best_ff, best_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;

   logic               accept;
   logic [CW-1:0]      size_c, depth_c, limit_c, idx_c, qry_c;
   logic               upd_ok;
   logic [NW-1:0]      up_next, down_next;
   logic               up_more, down_more, clear_last;
   logic [VALUE_W-1:0] down_best;

   assign accept  = start && !busy;
   assign size_c  = CW'(size_in_use);
   assign depth_c = CW'(DEPTH);
   assign limit_c = (size_c > depth_c) ? depth_c : size_c;
   assign idx_c   = CW'(req_index);
   assign qry_c   = (idx_c > limit_c) ? limit_c : idx_c;
   assign upd_ok  = (idx_c != '0) && (idx_c <= limit_c);

   assign up_next    = node_ff + (node_ff & (~node_ff + NW'(1)));
   assign up_more    = (CW'(up_next) <= limit_c);
   assign down_next  = node_ff & (node_ff - NW'(1));
   assign down_more  = (down_next != '0);
   assign clear_last = (node_ff == NW'(DEPTH - 1));
   assign down_best  = ($signed(rd_data) < $signed(best_ff)) ? rd_data : best_ff;

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_prefix_min = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  OP_UPDATE: if (upd_ok) state_in = ST_UP;
                  OP_QUERY:  if (qry_c != '0) state_in = ST_DOWN;
                  OP_CLEAR:  state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_UP: begin
            if (!up_more) begin
               state_in = ST_IDLE;
            end
         end
         ST_DOWN: begin
            if (!down_more) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      node_in      = node_ff;
      val_in       = val_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(node_ff - NW'(1));
      wr_data      = val_ff;
      rd_addr      = AW'(node_ff - NW'(1));
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(node_ff);
            wr_data = EMPTY_VALUE;
            node_in = clear_last ? '0 : node_ff + NW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  OP_UPDATE: begin
                     node_in = NW'(idx_c);
                     rd_addr = AW'(idx_c - CW'(1));
                     val_in  = req_value;
                  end
                  OP_QUERY: begin
                     node_in = NW'(qry_c);
                     rd_addr = AW'(qry_c - CW'(1));
                     best_in = EMPTY_VALUE;
                     // empty prefix answers at once
                     if (qry_c == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = EMPTY_VALUE;
                     end
                  end
                  OP_CLEAR: begin
                     node_in = '0;
                  end
                  default: begin
                     node_in = node_ff;
                  end
               endcase
            end
         end
         ST_UP: begin
            // rd_data holds the node read in the previous cycle
            wr_en   = ($signed(val_ff) < $signed(rd_data));
            node_in = up_next;
            rd_addr = AW'(up_next - NW'(1));
         end
         ST_DOWN: begin
            best_in = down_best;
            node_in = down_next;
            rd_addr = AW'(down_next - NW'(1));
            if (!down_more) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = down_best;
            end
         end
         default: begin
            node_in = node_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
